>>> design/rm2ea_pkg.sv
// Shared types, constants and helper functions for the rotation-to-Euler core.
`timescale 1ns / 1ps
package rm2ea_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ISQ_STEPS     = 19;              // radicand below 2^37, two bits a step
    localparam int CD_LAT        = CORDIC_STAGES + 2;

    localparam int ELEM_W   = 16;
    localparam int ANG_W    = 16;
    localparam int THR_W    = 11;
    localparam int PAIR_W   = 17;                   // negated element needs one more bit
    localparam int CD_IN_W  = 20;
    localparam int CD_W     = 36;
    localparam int Z_W      = 34;
    localparam int SQ_W     = 38;
    localparam int PROD_W   = 32;
    localparam int CD_SCALE = 12;

    localparam logic [THR_W-1:0]      THR_RESET   = THR_W'(2);
    localparam logic signed [17:0]    PI_Q13      = 18'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] Z_ROUND     = 34'sd65536;
    localparam int                    Z_SHIFT     = 17;

    localparam logic [31:0] ATAN_TAB [0:23] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
    };

    typedef enum logic [1:0] {
        MODE_XYZ = 2'd0,
        MODE_YZX = 2'd1,
        MODE_ZXY = 2'd2
    } t_mode;

    // per-item control traveling beside the datapath
    typedef struct packed {
        logic [1:0] mode;
        logic       lock;
        logic       p_neg;
        logic       fold_neg;
        logic       tv_neg;
    } t_side;

    // operands of the three arctangent units
    typedef struct packed {
        logic signed [CD_IN_W-1:0] py;
        logic signed [CD_IN_W-1:0] ny;
        logic signed [CD_IN_W-1:0] ty;
        logic signed [CD_IN_W-1:0] tx;
    } t_cdin;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } t_isq;

    // one restoring step of the integer square root
    function automatic t_isq isq_step(input t_isq cur, input logic [SQ_W-1:0] bitv);
        t_isq nxt;
        logic [SQ_W-1:0] trial;
        trial = cur.res + bitv;
        if (cur.rem >= trial) begin
            nxt.rem = cur.rem - trial;
            nxt.res = (cur.res >> 1) + bitv;
        end else begin
            nxt.rem = cur.rem;
            nxt.res = cur.res >> 1;
        end
        return nxt;
    endfunction

endpackage

>>> design/rotation_matrix_to_euler_angles_core.sv
// Top level: rotation matrix to Euler angles with gimbal-lock detection.
`timescale 1ns / 1ps
// Converts one 3x3 rotation matrix (signed Q2.14) per beat into x, y and z
// Euler angles (signed Q3.13 radians) plus a gimbal-lock flag, for the
// rotation order XYZ, YZX or ZXY carried in s_axis_tuser (code 3 returns all
// zeros with no lock). A matrix enters on every clock and its result passes
// through one selection stage, one squaring stage, one lock-decision stage,
// nineteen square-root steps, the arctangent pipelines and an output
// register. The rate is one beat per clock; the whole pipeline holds when
// the output register is full and not taken, so a stall drops or repeats
// nothing. Write lock_threshold through the cfg channel (always ready) only
// while no beat is in flight; it resets to 2 Q2.14 units.
module rotation_matrix_to_euler_angles_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rm2ea_pkg::THR_W-1:0]   i_cfg_data,     // lock_threshold
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each)
    input  logic [143:0]                  s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,   // mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,   // x_angle, y_angle, z_angle
    output logic [0:0]                    m_axis_tuser    // gimbal_lock
);
    import rm2ea_pkg::*;

    // configuration
    logic [THR_W-1:0] r_thr;

    // pipeline control
    logic en;
    logic r_v1, r_v2, r_v3;
    logic r_vq [0:ISQ_STEPS];
    logic r_vc [0:CD_LAT-1];
    logic r_ovalid;

    // stage 1: element selection
    logic signed [ELEM_W-1:0] r1_p, r1_num;
    logic signed [PAIR_W-1:0] r1_ty, r1_tx, r1_ly, r1_lx;
    t_side                    r1_side;

    // stage 2: squares
    logic signed [PROD_W-1:0] r2_p2, r2_n2;
    logic signed [ELEM_W-1:0] r2_p, r2_num;
    logic signed [PAIR_W-1:0] r2_ty, r2_tx, r2_ly, r2_lx;
    t_side                    r2_side;

    // square-root pipeline, index 0 is the lock-decision register
    t_isq  r_qa [0:ISQ_STEPS];
    t_isq  r_qb [0:ISQ_STEPS];
    t_cdin r_qcd [0:ISQ_STEPS];
    t_side r_qside [0:ISQ_STEPS];

    // side data alongside the arctangent units
    t_side r_cside [0:CD_LAT-1];

    logic signed [ANG_W-1:0] a_p, a_n, a_t;
    logic [47:0] r_tdata;
    logic        r_tlock;

    // -------- configuration port --------
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // advance everything unless a result waits untaken
    assign en            = !r_ovalid || m_axis_tready;
    assign s_axis_tready = en;

    // -------- stage 1: pick pivot, numerator, fold and arctangent pairs --------
    logic signed [ELEM_W-1:0] e [0:8];
    logic signed [ELEM_W-1:0] s_p, s_num, s_fold;
    logic signed [PAIR_W-1:0] s_ty, s_tx, s_ly, s_lx;
    logic                     s_tvneg;
    logic signed [17:0]       p_ext, thr_ext;
    logic                     s_plock;

    for (genvar k = 0; k < 9; k++) begin : g_elem
        assign e[k] = s_axis_tdata[ELEM_W*k +: ELEM_W];
    end

    always_comb begin
        s_p = '0; s_num = '0; s_fold = '0;
        s_ty = '0; s_tx = '0; s_ly = '0; s_lx = '0;
        s_tvneg = 1'b0;
        case (s_axis_tuser)
            MODE_XYZ: begin
                s_p = e[2]; s_num = e[5]; s_fold = e[8];
                s_ty = PAIR_W'(e[1]); s_tx = PAIR_W'(e[0]);
                s_ly = -PAIR_W'(e[3]); s_lx = PAIR_W'(e[4]);
                s_tvneg = 1'b1;
            end
            MODE_YZX: begin
                s_p = e[3]; s_num = e[6]; s_fold = e[0];
                s_ty = PAIR_W'(e[5]); s_tx = PAIR_W'(e[4]);
                s_ly = -PAIR_W'(e[7]); s_lx = PAIR_W'(e[8]);
                s_tvneg = 1'b1;
            end
            MODE_ZXY: begin
                s_p = e[7]; s_num = e[1]; s_fold = e[4];
                s_ty = PAIR_W'(e[6]); s_tx = PAIR_W'(e[8]);
                s_ly = -PAIR_W'(e[2]); s_lx = PAIR_W'(e[0]);
            end
            default: begin
                s_p = '0;
            end
        endcase
        p_ext   = 18'(s_p);
        thr_ext = signed'({7'b0, r_thr});
        // pivot within the threshold of plus or minus one
        s_plock = (p_ext > 18'sd16384 - thr_ext) || (p_ext < thr_ext - 18'sd16384);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p   <= s_p;
            r1_num <= s_num;
            r1_ty  <= s_ty;
            r1_tx  <= s_tx;
            r1_ly  <= s_ly;
            r1_lx  <= s_lx;
            r1_side.mode     <= s_axis_tuser;
            r1_side.lock     <= s_plock;
            r1_side.p_neg    <= s_p[ELEM_W-1];
            r1_side.fold_neg <= s_fold[ELEM_W-1];
            r1_side.tv_neg   <= s_tvneg;
        end
    end

    // -------- stage 2: square pivot and numerator --------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p2   <= PROD_W'(r1_p) * PROD_W'(r1_p);
            r2_n2   <= PROD_W'(r1_num) * PROD_W'(r1_num);
            r2_p    <= r1_p;
            r2_num  <= r1_num;
            r2_ty   <= r1_ty;
            r2_tx   <= r1_tx;
            r2_ly   <= r1_ly;
            r2_lx   <= r1_lx;
            r2_side <= r1_side;
        end
    end

    // -------- stage 3: argument test, radicands, arctangent operands --------
    logic signed [32:0] c2, d2;
    logic               s_arglock, s_lock;
    t_side              s3_side;
    t_cdin              s3_cd;

    always_comb begin
        c2        = 33'sd268435456 - 33'(r2_p2);
        d2        = c2 - 33'(r2_n2);
        s_arglock = 33'(r2_n2) > c2;
        s_lock    = r2_side.lock || s_arglock;
        s3_side        = r2_side;
        s3_side.lock   = s_lock;
        s3_side.tv_neg = r2_side.tv_neg && s_lock;
        s3_cd.py = CD_IN_W'(r2_p) <<< 4;
        s3_cd.ny = CD_IN_W'(r2_num) <<< 4;
        s3_cd.ty = s_lock ? CD_IN_W'(r2_ly) : CD_IN_W'(r2_ty);
        s3_cd.tx = s_lock ? CD_IN_W'(r2_lx) : CD_IN_W'(r2_tx);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // radicands are meaningful only off the lock path
            r_qa[0].rem <= SQ_W'({c2[28:0], 8'b0});
            r_qa[0].res <= '0;
            r_qb[0].rem <= SQ_W'({d2[28:0], 8'b0});
            r_qb[0].res <= '0;
            r_qcd[0]    <= s3_cd;
            r_qside[0]  <= s3_side;
        end
    end

    // -------- square-root steps --------
    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qa[k+1]    <= isq_step(r_qa[k], BITV);
                r_qb[k+1]    <= isq_step(r_qb[k], BITV);
                r_qcd[k+1]   <= r_qcd[k];
                r_qside[k+1] <= r_qside[k];
            end
        end
    end

    // -------- arctangent units --------
    rm2ea_cordic u_cd_pivot (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_qcd[ISQ_STEPS].py),
        .i_x     (signed'(r_qa[ISQ_STEPS].res[CD_IN_W-1:0])),
        .o_angle (a_p)
    );

    rm2ea_cordic u_cd_asin (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_qcd[ISQ_STEPS].ny),
        .i_x     (signed'(r_qb[ISQ_STEPS].res[CD_IN_W-1:0])),
        .o_angle (a_n)
    );

    rm2ea_cordic u_cd_atan (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_qcd[ISQ_STEPS].ty),
        .i_x     (r_qcd[ISQ_STEPS].tx),
        .o_angle (a_t)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cside[0] <= r_qside[ISQ_STEPS];
        end
    end

    for (genvar k = 1; k < CD_LAT; k++) begin : g_cside
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cside[k] <= r_cside[k-1];
            end
        end
    end

    // -------- output composition --------
    t_side                   f_side;
    logic signed [ANG_W-1:0] f_pv, f_av, f_tv, f_x, f_y, f_z;
    logic signed [17:0]      fold_t;
    logic                    f_lock;

    always_comb begin
        f_side = r_cside[CD_LAT-1];
        fold_t = PI_Q13 - 18'(a_n);
        if (f_side.lock) begin
            f_pv = f_side.p_neg ? HALF_PI_Q13 : -HALF_PI_Q13;
            f_av = '0;
        end else begin
            f_pv = -a_p;
            if (!f_side.fold_neg) begin
                f_av = a_n;
            end else if (fold_t > 18'sd32767) begin
                f_av = 16'sd32767;
            end else begin
                f_av = fold_t[ANG_W-1:0];
            end
        end
        f_tv   = f_side.tv_neg ? -a_t : a_t;
        f_lock = f_side.lock;
        case (f_side.mode)
            MODE_XYZ: begin
                f_x = f_av; f_y = f_pv; f_z = f_tv;
            end
            MODE_YZX: begin
                f_x = f_tv; f_y = f_av; f_z = f_pv;
            end
            MODE_ZXY: begin
                f_x = f_pv; f_y = f_tv; f_z = f_av;
            end
            default: begin
                f_x = '0; f_y = '0; f_z = '0; f_lock = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= {f_z, f_y, f_x};
            r_tlock <= f_lock;
        end
    end

    // -------- valid bits --------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_v1     <= s_axis_tvalid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_ovalid <= r_vc[CD_LAT-1];
        end
    end

    assign r_vq[0] = r_v3;

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_vq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vq[k+1] <= 1'b0;
            end else if (en) begin
                r_vq[k+1] <= r_vq[k];
            end
        end
    end

    for (genvar k = 0; k < CD_LAT; k++) begin : g_vc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[k] <= 1'b0;
            end else if (en) begin
                r_vc[k] <= (k == 0) ? r_vq[ISQ_STEPS] : r_vc[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tlock;

endmodule

>>> design/rm2ea_cordic.sv
// Pipelined vectoring CORDIC arctangent, one micro-rotation per stage.
`timescale 1ns / 1ps
module rm2ea_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [rm2ea_pkg::CD_IN_W-1:0]   i_y,
    input  logic signed [rm2ea_pkg::CD_IN_W-1:0]   i_x,
    output logic signed [rm2ea_pkg::ANG_W-1:0]     o_angle
);
    import rm2ea_pkg::*;

    logic signed [CD_W-1:0] r_x    [0:CORDIC_STAGES];
    logic signed [CD_W-1:0] r_y    [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_z    [0:CORDIC_STAGES];
    logic                   r_zero [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_angle;

    logic signed [CD_W-1:0] n_x0, n_y0, xs, ys;
    logic signed [Z_W-1:0]  n_z0, zr;

    // pre-rotate the left half plane onto the right
    always_comb begin
        xs = CD_W'(i_x) <<< CD_SCALE;
        ys = CD_W'(i_y) <<< CD_SCALE;
        n_x0 = xs;
        n_y0 = ys;
        n_z0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_x0 = ys;
                n_y0 = -xs;
                n_z0 = HALF_PI_Q30;
            end else begin
                n_x0 = -ys;
                n_y0 = xs;
                n_z0 = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[i]);
        logic signed [CD_W-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][CD_W-1]) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ANG;
                end
            end
        end
    end

    assign zr = (r_z[CORDIC_STAGES] + Z_ROUND) >>> Z_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[CORDIC_STAGES] ? '0 : zr[ANG_W-1:0];
        end
    end

    assign o_angle = r_angle;

endmodule

>>> tb/sv/rotation_matrix_to_euler_angles_core_tb.sv
// Self-checking testbench for the rotation-matrix-to-Euler-angles core.
`timescale 1ns / 1ps
// Random matrices stream into the core, and an internal predictor computes
// the angles that each accepted matrix should produce.
// Most matrices are true rotations built from random angles. Some have one
// pivot element forced near +1 or -1 so that the gimbal-lock path is exercised.
// The rest are random elements drawn over the whole 16-bit range.
// The threshold register is rewritten between phases, only after the core
// has drained. Both sides idle in random bursts, except in the last phase.
module rotation_matrix_to_euler_angles_core_tb;
    import rm2ea_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 310;

    typedef struct {
        logic [1:0]        mode;
        logic signed [15:0] r [9];
    } t_matrix;

    typedef struct {
        logic [15:0] x, y, z;
        logic        lock;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    t_matrix matrix_q[$];
    t_angles angles_q[$];
    int unsigned thr_now = 2;
    int err_cnt = 0;
    int beats_in = 0;
    int beats_out = 0;
    int lock_cnt = 0;
    int cycle_cnt = 0;
    bit calm = 1'b0;                          // no idling in the final phase

    rotation_matrix_to_euler_angles_core dut (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic int atan2_q13(longint y, longint x);
        longint z, xn, yn, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 4096;
        y = y * 4096;
        // fold the left half plane onto the right one
        if (x < 0) begin
            if (y >= 0) begin
                xn = y;  yn = -x; z = HALF_PI_Q30;
            end else begin
                xn = -y; yn = x;  z = -HALF_PI_Q30;
            end
            x = xn;
            y = yn;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        return int'((z + 65536) >>> 17);
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 36;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // pivot angle, asin angle and atan angle for one rotation order
    function automatic bit solve_order(int p, int num, int fold, int ty, int tx, int lock_t,
                                       int thr, output int pv, output int av, output int tv);
        longint c2, n2;
        int a;
        c2 = 0;
        n2 = 0;
        if (p > 16384 - thr || p < -16384 + thr) begin
            pv = p < 0 ? HALF_PI_Q13 : -HALF_PI_Q13;
            av = 0;
            tv = lock_t;
            return 1'b1;
        end
        c2 = 64'sd268435456 - longint'(p) * p;
        n2 = longint'(num) * num;
        if (n2 > c2) begin
            pv = p < 0 ? HALF_PI_Q13 : -HALF_PI_Q13;
            av = 0;
            tv = lock_t;
            return 1'b1;
        end
        pv = -atan2_q13(longint'(p) * 16, floor_sqrt(longint'(c2) << 8));
        a = atan2_q13(longint'(num) * 16, floor_sqrt(longint'(c2 - n2) << 8));
        if (fold < 0) begin
            a = 25736 - a;
            if (a > 32767) a = 32767;
        end
        av = a;
        tv = atan2_q13(ty, tx);
        return 1'b0;
    endfunction

    function automatic t_angles predict_angles(t_matrix m, int thr);
        t_angles o;
        int r [9];
        int x, y, z;
        bit lk;
        x = 0; y = 0; z = 0; lk = 1'b0;
        for (int i = 0; i < 9; i++) r[i] = m.r[i];
        case (m.mode)
            MODE_XYZ: lk = solve_order(r[2], r[5], r[8], r[1], r[0],
                                       -atan2_q13(-r[3], r[4]), thr, y, x, z);
            MODE_YZX: lk = solve_order(r[3], r[6], r[0], r[5], r[4],
                                       -atan2_q13(-r[7], r[8]), thr, z, y, x);
            MODE_ZXY: lk = solve_order(r[7], r[1], r[4], r[6], r[8],
                                       atan2_q13(-r[2], r[0]), thr, x, z, y);
            default: ;                        // unused order: all zero
        endcase
        o.x = 16'(x);
        o.y = 16'(y);
        o.z = 16'(z);
        o.lock = lk;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [15:0] to_q14(real v);
        int q;
        q = $rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5));
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    function automatic real rand_angle();
        return $itor($urandom_range(0, 62831)) / 10000.0 - 3.14159;
    endfunction

    // R = Rz(c) * Ry(b) * Rx(a), rounded to Q2.14
    function automatic t_matrix rotation(logic [1:0] mode);
        t_matrix m;
        real a, b, c, ca, sa, cb, sb, cc, sc;
        a = rand_angle(); b = rand_angle(); c = rand_angle();
        ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b);
        cc = $cos(c); sc = $sin(c);
        m.mode = mode;
        m.r[0] = to_q14(cc * cb);
        m.r[1] = to_q14(cc * sb * sa - sc * ca);
        m.r[2] = to_q14(cc * sb * ca + sc * sa);
        m.r[3] = to_q14(sc * cb);
        m.r[4] = to_q14(sc * sb * sa + cc * ca);
        m.r[5] = to_q14(sc * sb * ca - cc * sa);
        m.r[6] = to_q14(-sb);
        m.r[7] = to_q14(cb * sa);
        m.r[8] = to_q14(cb * ca);
        return m;
    endfunction

    function automatic int pivot_slot(logic [1:0] mode);
        case (mode)
            MODE_XYZ: return 2;
            MODE_YZX: return 3;
            default:  return 7;
        endcase
    endfunction

    function automatic t_matrix random_item();
        t_matrix m;
        int kind, k;
        logic [1:0] mode;
        kind = $urandom_range(0, 99);
        mode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        m = rotation(mode);
        if (kind < 20) begin
            // pivot pushed close to plus or minus one
            k = $urandom_range(0, 1100);
            m.r[pivot_slot(mode)] = $urandom_range(0, 1) ? 16'(16384 - k) : 16'(-16384 + k);
        end else if (kind < 35) begin
            for (int i = 0; i < 9; i++) m.r[i] = 16'($urandom);
        end
        return m;
    endfunction

    function automatic t_matrix fixed_item(logic [1:0] mode, int a0, int a1, int a2,
                                           int a3, int a4, int a5, int a6, int a7, int a8);
        t_matrix m;
        m.mode = mode;
        m.r[0] = 16'(a0); m.r[1] = 16'(a1); m.r[2] = 16'(a2);
        m.r[3] = 16'(a3); m.r[4] = 16'(a4); m.r[5] = 16'(a5);
        m.r[6] = 16'(a6); m.r[7] = 16'(a7); m.r[8] = 16'(a8);
        return m;
    endfunction

    task automatic write_threshold(int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= THR_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        thr_now = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (matrix_q.size() != 0 || angles_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // driver: present the oldest pending matrix, idle in bursts
    // ---------------------------------------------------------------
    int src_gap = 0;
    always @(posedge i_clk) begin
        logic [143:0] beat_data;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                angles_q.push_back(predict_angles(matrix_q.pop_front(), thr_now));
                beats_in++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the beat until it is taken
            end else if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!calm && matrix_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(1, 19) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (matrix_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= matrix_q[0].mode;
                for (int i = 0; i < 9; i++) beat_data[16*i +: 16] = matrix_q[0].r[i];
                s_axis_tdata <= beat_data;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random back-pressure, compare each result beat
    // ---------------------------------------------------------------
    int snk_gap = 0;
    always @(posedge i_clk) begin
        t_angles want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, angles_q.size());
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (angles_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h/%b",
                         $time, m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                want = angles_q.pop_front();
                if (want.lock) lock_cnt++;
                if (m_axis_tdata[15:0] !== want.x) begin
                    $display("%0t x_angle: expected %0d, actual %0d", $time,
                             $signed(want.x), $signed(m_axis_tdata[15:0]));
                    err_cnt++;
                end
                if (m_axis_tdata[31:16] !== want.y) begin
                    $display("%0t y_angle: expected %0d, actual %0d", $time,
                             $signed(want.y), $signed(m_axis_tdata[31:16]));
                    err_cnt++;
                end
                if (m_axis_tdata[47:32] !== want.z) begin
                    $display("%0t z_angle: expected %0d, actual %0d", $time,
                             $signed(want.z), $signed(m_axis_tdata[47:32]));
                    err_cnt++;
                end
                if (m_axis_tuser[0] !== want.lock) begin
                    $display("%0t gimbal_lock: expected %b, actual %b", $time,
                             want.lock, m_axis_tuser[0]);
                    err_cnt++;
                end
            end
        end
        if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            snk_gap = $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // sequence of phases
    // ---------------------------------------------------------------
    int unsigned thr_plan [6];
    initial begin
        thr_plan = '{2, 0, 1024, 1023, 0, 1};
        thr_plan[4] = $urandom_range(0, 1024);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(thr_plan[ph]);
            if (ph == 5) calm = 1'b1;
            if (ph < 2) begin
                // identity, zero matrix and the unused order
                for (int md = 0; md < 4; md++) begin
                    matrix_q.push_back(fixed_item(2'(md), 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
                    matrix_q.push_back(fixed_item(2'(md), 0, 0, 0, 0, 0, 0, 0, 0, 0));
                end
                // field extremes
                matrix_q.push_back(fixed_item(MODE_XYZ, 32767, 32767, 32767, 32767, 32767,
                                              32767, 32767, 32767, 32767));
                matrix_q.push_back(fixed_item(MODE_YZX, -32768, -32768, -32768, -32768,
                                              -32768, -32768, -32768, -32768, -32768));
                matrix_q.push_back(fixed_item(MODE_ZXY, -1, -1, -1, -1, -1, -1, -1, -1, -1));
                // atan2 on the negative x axis, with the fold element negative in the XYZ case
                matrix_q.push_back(fixed_item(MODE_XYZ, -16384, 0, 0, 0, -16384, 100, 0, 0,
                                              -16384));
                matrix_q.push_back(fixed_item(MODE_YZX, 0, 0, 0, 0, -16384, 0, 100, -1, -16384));
                // pivot exactly at plus and minus one, num zero and nonzero
                matrix_q.push_back(fixed_item(MODE_XYZ, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
                matrix_q.push_back(fixed_item(MODE_XYZ, 0, 0, -16384, 0, 0, 5, 0, 0, 0));
                matrix_q.push_back(fixed_item(MODE_YZX, 0, 0, 0, -16384, 0, 0, 0, 0, 0));
                matrix_q.push_back(fixed_item(MODE_ZXY, 0, 7, 0, 0, 0, 0, 0, 16384, 0));
                // asin argument beyond one, and a negative fold with the asin argument near one
                matrix_q.push_back(fixed_item(MODE_ZXY, 0, 16000, 0, 0, -16384, 0, 0, 8000, 0));
                matrix_q.push_back(fixed_item(MODE_XYZ, 0, 0, 0, 0, 0, 16383, 0, 0, -1));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) matrix_q.push_back(random_item());
            wait_drained();
        end
        $display("covered %0d matrices over 6 threshold settings, %0d of them locked",
                 beats_in, lock_cnt);
        $display("%0d result beats checked, %0d mismatches", beats_out, err_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
